[design/wpr_pkg.sv]
package wpr_pkg;

  localparam int MaxNodes     = 64;
  localparam int IdxW         = 6;
  localparam int RankFracBits = 30;
  localparam int RankW        = 32;
  localparam int CntW         = 7;
  localparam int HalfW        = 8;
  localparam int SiW          = 13;
  localparam int SoW          = 14;
  localparam int DivW         = 40;
  localparam int AccW         = 40;
  localparam int SweepW       = 16;
  localparam int DampW        = 16;
  localparam int CfgIdxW      = 2;
  localparam int CfgDataW     = 32;

  localparam logic [RankW-1:0] RankCap = {RankW{1'b1}};

  typedef enum logic [1:0] {
    ActLoad = 2'd0,
    ActEdge = 2'd1,
    ActRun  = 2'd2
  } action_e;

  localparam logic [CfgIdxW-1:0] CfgDamping   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgThreshold = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxIter   = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgNodeCount = 2'd3;

  // Write request into the graph store
  typedef struct packed {
    logic            cnt_we;
    logic            edge_we;
    logic [IdxW-1:0] node;
    logic [IdxW-1:0] target;
    logic            edge_bit;
    logic [CntW-1:0] in_links;
    logic [CntW-1:0] out_links;
  } wpr_wr_t;

  // Out count in half units: zero counts as one half
  function automatic logic [HalfW-1:0] half_out(input logic [CntW-1:0] cnt);
    half_out = (cnt == '0) ? HalfW'(1) : {cnt, 1'b0};
  endfunction

endpackage

[design/wpr_div.sv]
module wpr_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [wpr_pkg::DivW-1:0]  dividend_i,
  input  logic [wpr_pkg::SoW-1:0]   divisor_i,
  output logic                      done_o,
  output logic [wpr_pkg::DivW-1:0]  quot_o
);
  import wpr_pkg::*;

  localparam int CntBits = $clog2(DivW);

  logic               busy_q;
  logic               done_q;
  logic [CntBits-1:0] cnt_q;
  logic [SoW-1:0]     rem_q;
  logic [SoW-1:0]     dvs_q;
  logic [DivW-1:0]    quo_q;
  logic [SoW:0]       trial;
  logic               fits;

  assign trial = {rem_q, quo_q[DivW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= '0;
        dvs_q  <= divisor_i;
        quo_q  <= dividend_i;
      end else if (busy_q) begin
        rem_q <= fits ? SoW'(trial - {1'b0, dvs_q}) : SoW'(trial);
        quo_q <= {quo_q[DivW-2:0], fits};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntBits'(DivW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

[design/wpr_graph_store.sv]
module wpr_graph_store (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wpr_pkg::wpr_wr_t              wr_i,
  input  logic [wpr_pkg::IdxW-1:0]      row_addr_i,
  output logic [wpr_pkg::MaxNodes-1:0]  row_o,
  input  logic [wpr_pkg::IdxW-1:0]      cnt_addr_i,
  output logic [wpr_pkg::CntW-1:0]      in_cnt_o,
  output logic [wpr_pkg::CntW-1:0]      out_cnt_o
);
  import wpr_pkg::*;

  logic [MaxNodes-1:0]  adj_mem [MaxNodes];
  logic [2*CntW-1:0]    cnt_mem [MaxNodes];
  logic [MaxNodes-1:0]  row_vld_q;
  logic [MaxNodes-1:0]  cnt_vld_q;
  logic                 row_rd_vld_q;
  logic                 cnt_rd_vld_q;
  logic [MaxNodes-1:0]  row_q;
  logic [2*CntW-1:0]    cnt_q;

  // a row never written reads as zero: first write fills the whole row
  always_ff @(posedge clk_i) begin
    if (wr_i.edge_we) begin
      for (int j = 0; j < MaxNodes; j++) begin
        if (!row_vld_q[wr_i.node] || (IdxW'(j) == wr_i.target)) begin
          adj_mem[wr_i.node][j] <= (IdxW'(j) == wr_i.target) & wr_i.edge_bit;
        end
      end
    end
    if (wr_i.cnt_we) begin
      cnt_mem[wr_i.node] <= {wr_i.in_links, wr_i.out_links};
    end
    row_q <= adj_mem[row_addr_i];
    cnt_q <= cnt_mem[cnt_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q    <= '0;
      cnt_vld_q    <= '0;
      row_rd_vld_q <= 1'b0;
      cnt_rd_vld_q <= 1'b0;
    end else begin
      if (wr_i.edge_we) row_vld_q[wr_i.node] <= 1'b1;
      if (wr_i.cnt_we)  cnt_vld_q[wr_i.node] <= 1'b1;
      row_rd_vld_q <= row_vld_q[row_addr_i];
      cnt_rd_vld_q <= cnt_vld_q[cnt_addr_i];
    end
  end

  assign row_o     = row_rd_vld_q ? row_q : '0;
  assign in_cnt_o  = cnt_rd_vld_q ? cnt_q[2*CntW-1:CntW] : '0;
  assign out_cnt_o = cnt_rd_vld_q ? cnt_q[CntW-1:0] : '0;

endmodule

[design/weighted_pagerank_engine.sv]
// Load and edge requests take effect at the accepting edge; one per cycle, busy stays low.
// A run request first forms the link sums, then sets up the initial rank and base term with
// two serial divides and fills the rank bank, then runs sweeps with two serial divides per
// live edge, then emits one result strobe per page with a read state between strobes.
// Results cannot be stalled. Reset (rst_ni low, async) clears graph and counters and sets
// config to its defaults; rank memories are written by every run before they are read.
module weighted_pagerank_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    action_i,
  input  logic [wpr_pkg::IdxW-1:0]      node_index_i,
  input  logic [wpr_pkg::IdxW-1:0]      target_index_i,
  input  logic                          edge_present_i,
  input  logic [wpr_pkg::CntW-1:0]      in_links_i,
  input  logic [wpr_pkg::CntW-1:0]      out_links_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [wpr_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [wpr_pkg::CfgDataW-1:0]  cfg_data_i,
  output logic                          result_valid_o,
  output logic [wpr_pkg::IdxW-1:0]      page_index_o,
  output logic [wpr_pkg::RankW-1:0]     rank_o,
  output logic [wpr_pkg::SweepW-1:0]    sweeps_done_o,
  output logic                          last_o
);
  import wpr_pkg::*;

  typedef enum logic [4:0] {
    StIdle, StARow, StACnt, StAAcc, StAWr,
    StIS1, StIW1, StIS2, StIW2, StIFill,
    StCheck, StPRd, StPLat, StQRd, StQChk, StQD1, StQD2, StQNext,
    StPFin, StPWr, StSwEnd, StORd, StOEmit
  } state_e;

  // ---------------------------------------------------------------- config
  logic [DampW-1:0]  damping_q;
  logic [RankW-1:0]  thresh_q;
  logic [SweepW-1:0] max_iter_q;
  logic [CntW-1:0]   node_count_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      damping_q    <= 16'd55706;
      thresh_q     <= 32'd10737;
      max_iter_q   <= 16'd1000;
      node_count_q <= 7'd64;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgDamping:   damping_q    <= cfg_data_i[DampW-1:0];
        CfgThreshold: thresh_q     <= cfg_data_i[RankW-1:0];
        CfgMaxIter:   max_iter_q   <= cfg_data_i[SweepW-1:0];
        CfgNodeCount: node_count_q <= cfg_data_i[CntW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- state
  state_e              state_q;
  logic [IdxW-1:0]     p_q, q_q, nm1_q;
  logic                cur_q;          // bank holding the current ranks
  logic [SweepW-1:0]   sweep_q;
  logic [AccW-1:0]     acc_q, diff_q, sum_q;
  logic [RankW-1:0]    base_q, rank0_q, oldp_q;
  logic [CntW-1:0]     inp_q;
  logic [HalfW-1:0]    ohp_q;
  logic [SoW-1:0]      so_q;
  logic [SiW-1:0]      si_acc_q;
  logic [SoW-1:0]      so_acc_q;
  logic [RankW+DampW-1:0] prod_q;
  logic                res_valid_q, last_q;
  logic [IdxW-1:0]     page_q;
  logic [RankW-1:0]    rank_q;
  logic [SweepW-1:0]   sweeps_q;

  // ---------------------------------------------------------------- graph store
  wpr_wr_t             wr;
  logic [MaxNodes-1:0] row;
  logic [CntW-1:0]     in_cnt, out_cnt;
  logic                accept;

  assign accept      = start && !busy;
  assign wr.cnt_we   = accept && (action_i == ActLoad);
  assign wr.edge_we  = accept && (action_i == ActEdge);
  assign wr.node     = node_index_i;
  assign wr.target   = target_index_i;
  assign wr.edge_bit = edge_present_i;
  assign wr.in_links = in_links_i;
  assign wr.out_links = out_links_i;

  wpr_graph_store u_graph (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (wr),
    .row_addr_i (q_q),
    .row_o      (row),
    .cnt_addr_i (p_q),
    .in_cnt_o   (in_cnt),
    .out_cnt_o  (out_cnt)
  );

  // ---------------------------------------------------------------- rank and sum memories
  // Two banks of ranks, ping-pong per sweep: a sweep reads bank cur_q and writes the other.
  logic [RankW-1:0]   rank_mem [2*MaxNodes];
  logic [SiW+SoW-1:0] sums_mem [MaxNodes];
  logic               rk_we;
  logic [IdxW:0]      rk_waddr, rk_raddr;
  logic [RankW-1:0]   rk_wdata, rk_rdata_q;
  logic [SiW+SoW-1:0] sums_rdata_q;
  logic               sums_we;

  always_ff @(posedge clk_i) begin
    if (rk_we) rank_mem[rk_waddr] <= rk_wdata;
    rk_rdata_q <= rank_mem[rk_raddr];
    if (sums_we) sums_mem[q_q] <= {si_acc_q, so_acc_q};
    sums_rdata_q <= sums_mem[q_q];
  end

  // ---------------------------------------------------------------- divider
  logic             div_start, div_done;
  logic [DivW-1:0]  div_dividend, div_quot;
  logic [SoW-1:0]   div_divisor;

  wpr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // ---------------------------------------------------------------- datapath
  logic [SiW-1:0]   si_rd;
  logic [SoW-1:0]   so_rd;
  logic             edge_live;
  logic [RankW:0]   vsum;
  logic [RankW-1:0] v_new, v_diff;
  logic [RankW-1:0] sum_sat;
  logic [CntW-1:0]  n_clamped;
  logic [RankW+CntW-1:0]  in_prod;   // old rank times in count, full width
  logic [RankW+HalfW-1:0] out_prod;  // first quotient times half-unit out count

  assign si_rd     = sums_rdata_q[SiW+SoW-1:SoW];
  assign so_rd     = sums_rdata_q[SoW-1:0];
  assign edge_live = row[p_q] && (si_rd != '0) && (so_rd != '0);
  assign vsum      = {1'b0, base_q} + {1'b0, prod_q[RankW+DampW-1:DampW]};
  assign v_new     = vsum[RankW] ? RankCap : vsum[RankW-1:0];
  assign v_diff    = (v_new > oldp_q) ? (v_new - oldp_q) : (oldp_q - v_new);
  assign sum_sat   = (sum_q > AccW'(RankCap)) ? RankCap : sum_q[RankW-1:0];
  assign n_clamped = (node_count_q == '0) ? CntW'(1) :
                     (node_count_q > CntW'(MaxNodes)) ? CntW'(MaxNodes) : node_count_q;
  assign in_prod   = rk_rdata_q * inp_q;
  assign out_prod  = div_quot[RankW-1:0] * ohp_q;

  always_comb begin
    div_start    = 1'b0;
    div_dividend = DivW'(1) << RankFracBits;
    div_divisor  = SoW'({nm1_q, 1'b0} >> 1) + SoW'(1);
    rk_we        = 1'b0;
    rk_waddr     = {~cur_q, p_q};
    rk_wdata     = v_new;
    rk_raddr     = (state_q == StQRd) ? {cur_q, q_q} : {cur_q, p_q};
    sums_we      = (state_q == StAWr);
    case (state_q)
      StIS1: div_start = 1'b1;
      StIS2: begin
        div_start    = 1'b1;
        div_dividend = DivW'(17'h10000 - {1'b0, damping_q}) << (RankFracBits - DampW);
      end
      StIFill: begin
        rk_we    = 1'b1;
        rk_waddr = {cur_q, p_q};
        rk_wdata = rank0_q;
      end
      StQChk: begin
        div_start    = edge_live;
        div_dividend = DivW'(in_prod);
        div_divisor  = SoW'(si_rd);
      end
      StQD1: begin
        div_start    = div_done;
        div_dividend = DivW'(out_prod);
        div_divisor  = so_q;
      end
      StPWr: rk_we = 1'b1;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      p_q         <= '0;
      q_q         <= '0;
      nm1_q       <= '0;
      cur_q       <= 1'b0;
      sweep_q     <= '0;
      acc_q       <= '0;
      diff_q      <= '0;
      sum_q       <= '0;
      base_q      <= '0;
      rank0_q     <= '0;
      oldp_q      <= '0;
      inp_q       <= '0;
      ohp_q       <= '0;
      so_q        <= '0;
      si_acc_q    <= '0;
      so_acc_q    <= '0;
      prod_q      <= '0;
      res_valid_q <= 1'b0;
      last_q      <= 1'b0;
      page_q      <= '0;
      rank_q      <= '0;
      sweeps_q    <= '0;
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (accept && (action_i == ActRun)) begin
            nm1_q   <= IdxW'(n_clamped - 1'b1);
            q_q     <= '0;
            state_q <= StARow;
          end
        end
        // link sums per source page
        StARow: begin
          si_acc_q <= '0;
          so_acc_q <= '0;
          p_q      <= '0;
          state_q  <= StACnt;
        end
        StACnt: state_q <= StAAcc;
        StAAcc: begin
          if (row[p_q]) begin
            si_acc_q <= si_acc_q + SiW'(in_cnt);
            so_acc_q <= so_acc_q + SoW'(half_out(out_cnt));
          end
          if (p_q == nm1_q) begin
            state_q <= StAWr;
          end else begin
            p_q     <= p_q + 1'b1;
            state_q <= StACnt;
          end
        end
        StAWr: begin
          if (q_q == nm1_q) begin
            state_q <= StIS1;
          end else begin
            q_q     <= q_q + 1'b1;
            state_q <= StARow;
          end
        end
        // initial rank and base term
        StIS1: state_q <= StIW1;
        StIW1: begin
          if (div_done) begin
            rank0_q <= div_quot[RankW-1:0];
            state_q <= StIS2;
          end
        end
        StIS2: state_q <= StIW2;
        StIW2: begin
          if (div_done) begin
            base_q  <= div_quot[RankW-1:0];
            p_q     <= '0;
            cur_q   <= 1'b0;
            state_q <= StIFill;
          end
        end
        StIFill: begin
          if (p_q == nm1_q) begin
            sweep_q <= '0;
            acc_q   <= '0;
            state_q <= StCheck;
          end else begin
            p_q <= p_q + 1'b1;
          end
        end
        StCheck: begin
          p_q    <= '0;
          diff_q <= '0;
          if ((sweep_q < max_iter_q) &&
              ((sweep_q == '0) || (acc_q >= AccW'(thresh_q)))) begin
            state_q <= StPRd;
          end else begin
            state_q <= StORd;
          end
        end
        // one sweep: for each page, walk all sources
        StPRd: state_q <= StPLat;
        StPLat: begin
          oldp_q  <= rk_rdata_q;
          inp_q   <= in_cnt;
          ohp_q   <= half_out(out_cnt);
          q_q     <= '0;
          sum_q   <= '0;
          state_q <= StQRd;
        end
        StQRd: state_q <= StQChk;
        StQChk: begin
          so_q    <= so_rd;
          state_q <= edge_live ? StQD1 : StQNext;
        end
        StQD1: begin
          if (div_done) state_q <= StQD2;
        end
        StQD2: begin
          if (div_done) begin
            sum_q   <= sum_q + div_quot;
            state_q <= StQNext;
          end
        end
        StQNext: begin
          if (q_q == nm1_q) begin
            state_q <= StPFin;
          end else begin
            q_q     <= q_q + 1'b1;
            state_q <= StQRd;
          end
        end
        StPFin: begin
          prod_q  <= sum_sat * damping_q;
          state_q <= StPWr;
        end
        StPWr: begin
          diff_q <= diff_q + AccW'(v_diff);
          if (p_q == nm1_q) begin
            state_q <= StSwEnd;
          end else begin
            p_q     <= p_q + 1'b1;
            state_q <= StPRd;
          end
        end
        StSwEnd: begin
          cur_q   <= ~cur_q;
          acc_q   <= diff_q;
          sweep_q <= sweep_q + 1'b1;
          state_q <= StCheck;
        end
        // drain ranks: a read state, then an emit state, per page
        StORd: state_q <= StOEmit;
        StOEmit: begin
          res_valid_q <= 1'b1;
          rank_q      <= rk_rdata_q;
          page_q      <= p_q;
          sweeps_q    <= sweep_q;
          last_q      <= (p_q == nm1_q);
          if (p_q == nm1_q) begin
            state_q <= StIdle;
          end else begin
            p_q     <= p_q + 1'b1;
            state_q <= StORd;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign busy           = (state_q != StIdle);
  assign result_valid_o = res_valid_q;
  assign page_index_o   = page_q;
  assign rank_o         = rank_q;
  assign sweeps_done_o  = sweeps_q;
  assign last_o         = last_q;

`ifndef SYNTHESIS
  // a run request always makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (action_i == ActRun)) |=> busy)
    else $error("run request did not start");

  // the block only goes idle as the final result is shown
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> (result_valid_o && last_o))
    else $error("run ended without final result");

  // results never come in adjacent cycles
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("back to back result strobes");
`endif

endmodule

[tb/tb_weighted_pagerank_engine.sv]
module tb_weighted_pagerank_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import wpr_pkg::*;

  localparam logic [1:0] ActUnused   = 2'd3;
  localparam int         CycleLimit  = 4_000_000;
  localparam int         SettleCycles = 16;

  typedef struct {
    logic [1:0]      action;
    logic [IdxW-1:0] node;
    logic [IdxW-1:0] target;
    logic            edge_bit;
    logic [CntW-1:0] in_links;
    logic [CntW-1:0] out_links;
  } request_t;

  typedef struct {
    logic [IdxW-1:0]   page;
    logic [RankW-1:0]  rank;
    logic [SweepW-1:0] sweeps;
    logic              last;
  } page_rank_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                start = 1'b0;
  logic                busy;
  logic [1:0]          action_i = '0;
  logic [IdxW-1:0]     node_index_i = '0;
  logic [IdxW-1:0]     target_index_i = '0;
  logic                edge_present_i = 1'b0;
  logic [CntW-1:0]     in_links_i = '0;
  logic [CntW-1:0]     out_links_i = '0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                result_valid_o;
  logic [IdxW-1:0]     page_index_o;
  logic [RankW-1:0]    rank_o;
  logic [SweepW-1:0]   sweeps_done_o;
  logic                last_o;

  weighted_pagerank_engine u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .node_index_i   (node_index_i),
    .target_index_i (target_index_i),
    .edge_present_i (edge_present_i),
    .in_links_i     (in_links_i),
    .out_links_i    (out_links_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .page_index_o   (page_index_o),
    .rank_o         (rank_o),
    .sweeps_done_o  (sweeps_done_o),
    .last_o         (last_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the graph store and the registers; counts start at zero
  bit              link_bit [MaxNodes][MaxNodes];
  logic [CntW-1:0] in_cnt   [MaxNodes] = '{default: '0};
  logic [CntW-1:0] out_cnt  [MaxNodes] = '{default: '0};
  logic [15:0]     damp_reg  = 16'd55706;
  logic [31:0]     thresh_reg = 32'd10737;
  logic [15:0]     iter_reg  = 16'd1000;
  logic [6:0]      nodes_reg = 7'd64;

  request_t   pending_q[$];
  page_rank_t rank_q[$];

  int errors    = 0;
  int runs_seen = 0;
  int pages_seen = 0;
  int loads_sent = 0;
  int cycles    = 0;
  bit no_idle   = 1'b0;

  // Fixed-point multiply by a Q0.16 factor, truncating
  function automatic longint unsigned scale_q16(longint unsigned x, longint unsigned f);
    return (x >> 16) * f + (((x & 64'hFFFF) * f) >> 16);
  endfunction

  function automatic longint unsigned half_units(int p);
    return (out_cnt[p] == 0) ? 64'd1 : 64'd2 * out_cnt[p];
  endfunction

  // Apply one accepted request to the shadow and queue the ranks it produces
  function automatic void apply_request(request_t r);
    longint unsigned one, cap, base, diff, sum, t, v;
    longint unsigned in_sum[MaxNodes];
    longint unsigned out_sum[MaxNodes];
    longint unsigned prev[MaxNodes];
    longint unsigned next[MaxNodes];
    int n, sweeps;
    page_rank_t e;
    one = 64'd1 << RankFracBits;
    cap = (64'd1 << (RankFracBits + 2)) - 1;
    case (r.action)
      ActLoad: begin
        in_cnt[r.node]  = r.in_links;
        out_cnt[r.node] = r.out_links;
        return;
      end
      ActEdge: begin
        link_bit[r.node][r.target] = r.edge_bit;
        return;
      end
      ActRun: ;
      default: return;
    endcase
    n = (nodes_reg == 0) ? 1 : int'(nodes_reg);
    if (n > MaxNodes) n = MaxNodes;
    for (int q = 0; q < n; q++) begin
      in_sum[q]  = 0;
      out_sum[q] = 0;
      for (int p = 0; p < n; p++) begin
        if (link_bit[q][p]) begin
          in_sum[q]  += in_cnt[p];
          out_sum[q] += half_units(p);
        end
      end
    end
    for (int p = 0; p < n; p++) prev[p] = one / n;
    base = scale_q16(one, 65536 - damp_reg) / n;
    sweeps = 0;
    diff = 0;
    while (sweeps < iter_reg && (sweeps == 0 || diff >= thresh_reg)) begin
      diff = 0;
      for (int p = 0; p < n; p++) begin
        sum = 0;
        for (int q = 0; q < n; q++) begin
          if (!link_bit[q][p] || in_sum[q] == 0 || out_sum[q] == 0) continue;
          t = prev[q] * in_cnt[p] / in_sum[q];
          t = t * half_units(p) / out_sum[q];
          sum += t;
        end
        if (sum > cap) sum = cap;
        v = base + scale_q16(sum, damp_reg);
        if (v > cap) v = cap;
        next[p] = v;
        diff += (v > prev[p]) ? v - prev[p] : prev[p] - v;
      end
      for (int p = 0; p < n; p++) prev[p] = next[p];
      sweeps++;
    end
    for (int p = 0; p < n; p++) begin
      e.page   = IdxW'(p);
      e.rank   = (prev[p] > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prev[p][31:0];
      e.sweeps = SweepW'(sweeps);
      e.last   = (p + 1 == n);
      rank_q.push_back(e);
    end
    runs_seen++;
  endfunction

  // Gap after a request: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: hold start until the request is taken, then advance
  request_t cur_req;
  int       gap_left = 0;
  always @(posedge clk_i) begin
    bit taken;
    if (rst_ni) begin
      taken = start && !busy;
      if (taken) apply_request(cur_req);
      if (!start || taken) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_q.size() > 0) begin
          cur_req = pending_q.pop_front();
          action_i       <= cur_req.action;
          node_index_i   <= cur_req.node;
          target_index_i <= cur_req.target;
          edge_present_i <= cur_req.edge_bit;
          in_links_i     <= cur_req.in_links;
          out_links_i    <= cur_req.out_links;
          start <= 1'b1;
          gap_left = pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result strobe with the oldest expected rank
  always @(posedge clk_i) begin
    page_rank_t e;
    if (rst_ni && result_valid_o) begin
      if (rank_q.size() == 0) begin
        $display("%0t: unexpected result page %0d rank %h", $realtime, page_index_o, rank_o);
        errors++;
      end else begin
        e = rank_q.pop_front();
        pages_seen++;
        if (page_index_o !== e.page) begin
          $display("%0t: page_index expected %0d actual %0d", $realtime, e.page, page_index_o);
          errors++;
        end
        if (rank_o !== e.rank) begin
          $display("%0t: rank of page %0d expected %h actual %h",
                   $realtime, e.page, e.rank, rank_o);
          errors++;
        end
        if (sweeps_done_o !== e.sweeps) begin
          $display("%0t: sweeps_done expected %0d actual %0d",
                   $realtime, e.sweeps, sweeps_done_o);
          errors++;
        end
        if (last_o !== e.last) begin
          $display("%0t: last expected %0b actual %0b", $realtime, e.last, last_o);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout, %0d ranks still expected", $realtime, rank_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Register write; valid stays high across back-to-back writes
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgDamping:   damp_reg   = data[15:0];
      CfgThreshold: thresh_reg = data;
      CfgMaxIter:   iter_reg   = data[15:0];
      CfgNodeCount: nodes_reg  = data[6:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [15:0] damp, logic [31:0] thr, logic [15:0] iters,
                          logic [6:0] nodes);
    write_reg(CfgDamping, CfgDataW'(damp));
    write_reg(CfgThreshold, thr);
    write_reg(CfgMaxIter, CfgDataW'(iters));
    write_reg(CfgNodeCount, CfgDataW'(nodes));
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hold off until every expected rank has come and the block is quiet
  task automatic drain();
    do @(negedge clk_i);
    while (pending_q.size() > 0 || start || gap_left > 0 || rank_q.size() > 0 || busy);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic push_req(int act, int node, int tgt, int eb, int il, int ol);
    request_t r;
    r.action    = 2'(act);
    r.node      = IdxW'(node);
    r.target    = IdxW'(tgt);
    r.edge_bit  = 1'(eb);
    r.in_links  = CntW'(il);
    r.out_links = CntW'(ol);
    pending_q.push_back(r);
  endtask

  // Random request, mostly well-formed within the active pages
  task automatic push_random(int n);
    int r, lim;
    lim = (n < 1) ? 1 : n;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      push_req(ActLoad, $urandom_range(0, lim - 1), $urandom_range(0, 63), $urandom_range(0, 1),
               $urandom_range(0, 64), $urandom_range(0, 64));
      loads_sent++;
    end else if (r < 80)
      push_req(ActEdge, $urandom_range(0, lim - 1), $urandom_range(0, lim - 1),
               ($urandom_range(0, 3) != 0), $urandom_range(0, 64), $urandom_range(0, 64));
    else if (r < 88)
      push_req(ActRun, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 1),
               $urandom_range(0, 64), $urandom_range(0, 64));
    else if (r < 92)
      push_req(ActUnused, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 1),
               $urandom_range(0, 64), $urandom_range(0, 64));
    else
      // noise: any page, any pair, any counts
      push_req($urandom_range(0, 1), $urandom_range(0, 63), $urandom_range(0, 63),
               $urandom_range(0, 1), $urandom_range(0, 64), $urandom_range(0, 64));
  endtask

  initial begin
    int n, pick;
    logic [31:0] thr;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: no damping, loose threshold, three pages
    set_regs(16'd0, 32'hFFFF_FFFF, 16'hFFFF, 7'd3);
    push_req(ActLoad, 0, 0, 0, 0, 0);
    push_req(ActLoad, 1, 0, 0, 64, 64);
    push_req(ActLoad, 2, 63, 1, 63, 1);
    push_req(ActLoad, 63, 0, 0, 64, 0);
    push_req(ActEdge, 0, 1, 1, 0, 0);
    push_req(ActEdge, 1, 2, 1, 0, 0);
    push_req(ActEdge, 2, 0, 1, 0, 0);
    push_req(ActEdge, 0, 2, 1, 0, 0);
    push_req(ActEdge, 63, 62, 1, 0, 0);   // outside the active pages
    push_req(ActEdge, 1, 1, 1, 0, 0);
    push_req(ActEdge, 1, 1, 0, 0, 0);     // clear it again
    push_req(ActUnused, 63, 63, 1, 64, 64);
    push_req(ActRun, 0, 0, 0, 0, 0);
    drain();
    // Full damping, zero threshold, node count zero means one page
    set_regs(16'hFFFF, 32'd0, 16'd5, 7'd0);
    push_req(ActEdge, 0, 0, 1, 0, 0);
    push_req(ActRun, 0, 0, 0, 0, 0);
    drain();
    // Zero sweeps with an oversized node count
    set_regs(16'd55706, 32'hFFFF_FFFF, 16'd0, 7'd127);
    push_req(ActRun, 0, 0, 0, 0, 0);
    drain();
    // One full-size sweep
    set_regs(16'd55706, 32'hFFFF_FFFF, 16'd1, 7'd64);
    push_req(ActRun, 0, 0, 0, 0, 0);
    drain();
    set_regs(16'd55706, 32'd10737, 16'd3, 7'd2);
    push_req(ActEdge, 0, 1, 1, 0, 0);
    push_req(ActEdge, 1, 0, 1, 0, 0);
    push_req(ActRun, 0, 0, 0, 0, 0);
    drain();

    // Random phases
    for (int ph = 0; ph < 10; ph++) begin
      pick = $urandom_range(0, 9);
      n = (pick == 0) ? 1 : (pick == 1) ? 16 : $urandom_range(2, 8);
      pick = $urandom_range(0, 2);
      thr = (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
      no_idle = ($urandom_range(0, 3) == 0);
      set_regs(16'($urandom), thr,
               ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 4)), 7'(n));
      for (int i = 0; i < 40; i++) push_random(n);
      push_req(ActRun, 0, 0, 0, 0, 0);
      drain();
    end

    $display("Covered %0d runs, %0d page ranks checked, %0d count loads, %0d errors.",
             runs_seen, pages_seen, loads_sent, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[files.f]
design/wpr_pkg.sv
design/wpr_div.sv
design/wpr_graph_store.sv
design/weighted_pagerank_engine.sv
tb/tb_weighted_pagerank_engine.sv
